// ----- hdl/hds_pkg.sv -----
// Shared types and constants for the heat diffusion stencil block.
// Used by hds_alu and heat_diffusion_stencil_top; depends on nothing.
package hds_pkg;

  localparam int COLUMNS     = 20;
  localparam int MAX_ROWS    = 1024;
  localparam int GRID_DEPTH  = MAX_ROWS * COLUMNS;
  localparam int ADDR_W      = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
  localparam int CNT_W       = $clog2(GRID_DEPTH + 1);
  localparam int ROW_CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int ROW_IW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_IW      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam int CELL_W      = 28;
  localparam int SUM_W       = CELL_W + 2;
  localparam int DIFF_W      = CELL_W + 4;
  localparam int DIFFU_W     = 14;
  localparam int PROD_W      = DIFF_W + DIFFU_W + 1;
  localparam int ACC_W       = CELL_W + 20;
  localparam int STEP_W      = 20;
  localparam int ROWREG_W    = 11;
  localparam int CFG_DATA_W  = 20;
  localparam int CFG_IDX_W   = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSIVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT  = 2'd2;

  localparam logic [DIFFU_W-1:0]  DIFFUSIVITY_RST = 14'd6554;
  localparam logic [ROWREG_W-1:0] ROW_COUNT_RST   = 11'd1024;
  localparam logic [STEP_W-1:0]   ITER_LIMIT_RST  = 20'd100;

  // Request codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Per-cell sequence phases
  localparam logic [3:0] PH_RD_SELF  = 4'd0;
  localparam logic [3:0] PH_RD_UP    = 4'd1;
  localparam logic [3:0] PH_RD_DOWN  = 4'd2;
  localparam logic [3:0] PH_RD_LEFT  = 4'd3;
  localparam logic [3:0] PH_RD_RIGHT = 4'd4;
  localparam logic [3:0] PH_SUM_END  = 4'd5;
  localparam logic [3:0] PH_DIFF     = 4'd6;
  localparam logic [3:0] PH_MUL      = 4'd7;
  localparam logic [3:0] PH_WRITE    = 4'd8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STEP,
    S_MIN,
    S_MIN_END
  } state_t;

  typedef struct packed {
    logic              req_type;
    logic [CELL_W-1:0] cell_value;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] min_temp;
    logic [STEP_W-1:0] iterations_done;
    logic              stopped_early;
  } out_item_t;

endpackage

// ----- hdl/hds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No package dependency.
module hds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/hds_alu.sv -----
// Stencil update datapath: floor(self + d * (sum - 4*self)) in fixed point.
// Two register stages; depends on hds_pkg.
module hds_alu (
  input  logic                          clk,
  input  logic [hds_pkg::DIFFU_W-1:0]   diffusivity,
  input  logic [hds_pkg::CELL_W-1:0]    self_val,
  input  logic [hds_pkg::SUM_W-1:0]     nbr_sum,
  output logic [hds_pkg::CELL_W-1:0]    new_val
);
  import hds_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  always_ff @(posedge clk) begin
    diff <= $signed(DIFF_W'(nbr_sum)) - $signed(DIFF_W'({self_val, 2'b00}));
    prod <= $signed({1'b0, diffusivity}) * diff;
  end

  // Total is never negative, so the arithmetic shift floors exactly
  always_comb begin
    acc     = $signed({{(ACC_W-CELL_W-16){1'b0}}, self_val, 16'b0}) + ACC_W'(prod);
    new_val = acc[CELL_W+15:16];
  end

endmodule

// ----- hdl/heat_diffusion_stencil_top.sv -----
// Top level of the five-point Jacobi heat stencil.
// Depends on hds_pkg, hds_ram and hds_alu.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): a load request writes the next
//   grid cell in row-major order. A run request starts Jacobi steps over the
//   loaded grid and returns one result on the output
//   channel (out_valid/out_ready/out_data): grid minimum, step count, and
//   whether a step changed no cell.
//   Each cell update reads its five points through the single read port of
//   the grid memory, then runs difference, multiply and write-back phases;
//   a run ends with a minimum sweep over the memory.
//   The grid lives in two memories used ping-pong; a step reads one and
//   writes the other, then the roles swap.
//   Loads are taken while a result waits; a new run request is held until
//   the previous result has been taken by the receiver.
//   Reset clears control state and sets registers to defaults; grid
//   contents are undefined until loaded.
module heat_diffusion_stencil_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  hds_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output hds_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [hds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hds_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hds_pkg::*;

  logic [DIFFU_W-1:0]   diffusivity;
  logic [ROWREG_W-1:0]  row_count;
  logic [STEP_W-1:0]    iter_limit;

  state_t               state, state_next;
  logic [3:0]           phase;
  logic [ADDR_W-1:0]    idx;
  logic [ROW_IW-1:0]    row;
  logic [COL_IW-1:0]    col;
  logic [CNT_W-1:0]     load_ptr;
  logic [STEP_W-1:0]    step_count;
  logic                 unchanged;
  logic                 same;
  logic                 cur_sel;
  logic [CELL_W-1:0]    self_val;
  logic [SUM_W-1:0]     nbr_sum;
  logic [CELL_W-1:0]    min_val;
  logic                 min_vld;
  logic                 min_first;

  logic [ROW_CNT_W-1:0] rows_use;
  logic [ROW_IW-1:0]    rows_m1;
  logic [CNT_W-1:0]     cells;
  logic [ADDR_W-1:0]    cells_m1;
  logic [ADDR_W-1:0]    load_addr;
  logic [ADDR_W-1:0]    raddr;
  logic [ADDR_W-1:0]    waddr;
  logic [CELL_W-1:0]    wdata;
  logic [CELL_W-1:0]    rd0, rd1, rd_cur;
  logic [CELL_W-1:0]    new_val;
  logic                 we0, we1;
  logic                 in_fire, load_fire, run_fire;
  logic                 wr_cur, wr_nxt;
  logic                 last_cell, cell_same, step_same;
  logic [STEP_W-1:0]    step_inc;
  logic [CELL_W-1:0]    min_final;

  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (in_data.req_type == REQ_LOAD);
  assign run_fire  = in_fire && (in_data.req_type == REQ_RUN);
  assign in_ready  = (state == S_IDLE) && !((in_data.req_type == REQ_RUN) && out_valid);

  always_comb begin
    if (row_count == '0) begin
      rows_use = ROW_CNT_W'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows_use = ROW_CNT_W'(MAX_ROWS);
    end else begin
      rows_use = ROW_CNT_W'(row_count);
    end
    rows_m1   = ROW_IW'(rows_use - ROW_CNT_W'(1));
    cells     = CNT_W'(rows_use * COLUMNS);
    cells_m1  = ADDR_W'(cells - CNT_W'(1));
    load_addr = (load_ptr >= cells) ? '0 : ADDR_W'(load_ptr);
  end

  assign rd_cur    = cur_sel ? rd1 : rd0;
  assign last_cell = (idx == cells_m1);
  assign cell_same = (new_val == self_val);
  assign step_same = same && cell_same;
  assign step_inc  = step_count + STEP_W'(1);
  assign min_final = (min_vld && !min_first && (min_val < rd_cur)) ? min_val : rd_cur;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (run_fire) begin
          state_next = (iter_limit == '0) ? S_MIN : S_STEP;
        end
      end
      S_STEP: begin
        if (phase == PH_WRITE && last_cell && (step_same || step_inc >= iter_limit)) begin
          state_next = S_MIN;
        end
      end
      S_MIN: begin
        if (last_cell) begin
          state_next = S_MIN_END;
        end
      end
      S_MIN_END: state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Memory port control
  always_comb begin
    raddr  = idx;
    wr_cur = load_fire;
    wr_nxt = 1'b0;
    case (state)
      S_STEP: begin
        wr_nxt = (phase == PH_WRITE);
        case (phase)
          PH_RD_UP:    raddr = (row == '0) ? idx : idx - ADDR_W'(COLUMNS);
          PH_RD_DOWN:  raddr = (row == rows_m1) ? idx : idx + ADDR_W'(COLUMNS);
          PH_RD_LEFT:  raddr = (col == '0) ? idx : idx - ADDR_W'(1);
          PH_RD_RIGHT: raddr = (col == COL_IW'(COLUMNS - 1)) ? idx : idx + ADDR_W'(1);
          default:     raddr = idx;
        endcase
      end
      default: raddr = idx;
    endcase
    waddr = load_fire ? load_addr : idx;
    wdata = load_fire ? in_data.cell_value : new_val;
    we0   = cur_sel ? wr_nxt : wr_cur;
    we1   = cur_sel ? wr_cur : wr_nxt;
  end

  hds_ram #(.WIDTH(CELL_W), .DEPTH(GRID_DEPTH)) u_grid0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd0)
  );

  hds_ram #(.WIDTH(CELL_W), .DEPTH(GRID_DEPTH)) u_grid1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rd1)
  );

  hds_alu u_alu (
    .clk(clk), .diffusivity(diffusivity), .self_val(self_val),
    .nbr_sum(nbr_sum), .new_val(new_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      diffusivity <= DIFFUSIVITY_RST;
      row_count   <= ROW_COUNT_RST;
      iter_limit  <= ITER_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIFFUSIVITY: diffusivity <= cfg_data[DIFFU_W-1:0];
        REG_ROW_COUNT:   row_count   <= cfg_data[ROWREG_W-1:0];
        REG_ITER_LIMIT:  iter_limit  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the five-point operands as the reads return
  always_ff @(posedge clk) begin
    if (state == S_STEP) begin
      case (phase)
        PH_RD_UP:   self_val <= rd_cur;
        PH_RD_DOWN: nbr_sum  <= SUM_W'(rd_cur);
        PH_RD_LEFT, PH_RD_RIGHT, PH_SUM_END: nbr_sum <= nbr_sum + SUM_W'(rd_cur);
        default: ;
      endcase
    end
    if (min_vld) begin
      min_val <= min_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_RD_SELF;
      idx        <= '0;
      row        <= '0;
      col        <= '0;
      load_ptr   <= '0;
      step_count <= '0;
      unchanged  <= 1'b0;
      same       <= 1'b1;
      cur_sel    <= 1'b0;
      min_vld    <= 1'b0;
      min_first  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      min_vld   <= (state == S_MIN);
      min_first <= (state == S_MIN) && (idx == '0);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (load_fire) begin
            load_ptr <= CNT_W'(load_addr) + CNT_W'(1);
          end
          if (run_fire) begin
            load_ptr   <= '0;
            step_count <= '0;
            unchanged  <= 1'b0;
            same       <= 1'b1;
            idx        <= '0;
            row        <= '0;
            col        <= '0;
            phase      <= PH_RD_SELF;
          end
        end
        S_STEP: begin
          if (phase == PH_WRITE) begin
            phase <= PH_RD_SELF;
            if (last_cell) begin
              idx        <= '0;
              row        <= '0;
              col        <= '0;
              same       <= 1'b1;
              step_count <= step_inc;
              if (step_same) begin
                unchanged <= 1'b1;
              end else begin
                cur_sel <= !cur_sel;
              end
            end else begin
              same <= step_same;
              idx  <= idx + ADDR_W'(1);
              if (col == COL_IW'(COLUMNS - 1)) begin
                col <= '0;
                row <= row + ROW_IW'(1);
              end else begin
                col <= col + COL_IW'(1);
              end
            end
          end else begin
            phase <= phase + 4'd1;
          end
        end
        S_MIN: begin
          idx <= last_cell ? '0 : idx + ADDR_W'(1);
        end
        S_MIN_END: begin
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Result register, loaded as the minimum sweep finishes
  always_ff @(posedge clk) begin
    if (state == S_MIN_END) begin
      out_data.min_temp        <= min_final;
      out_data.iterations_done <= step_count;
      out_data.stopped_early   <= unchanged;
    end
  end

endmodule
